/* hw/rtl/sceex_pkg.sv */
package sceex_pkg;

    // Default number of bytes in one sensor report
    localparam int REPORT_BYTES_DEF = 10;

    // Field widths
    localparam int IDX_W  = 4;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;
    localparam int DEC_W  = 3;
    localparam int SENS_W = 5;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One changed byte waiting for event generation
    typedef struct packed {
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] diff;
    } sceex_rec_t;

endpackage

/* hw/rtl/sceex_if.sv */
interface sceex_in_if;
    logic                         valid;
    logic                         ready;
    logic [sceex_pkg::IDX_W-1:0]  byte_index;
    logic [sceex_pkg::BYTE_W-1:0] byte_value;

    modport source (output valid, output byte_index, output byte_value, input ready);
    modport sink   (input valid, input byte_index, input byte_value, output ready);
endinterface

interface sceex_out_if;
    logic                         valid;
    logic                         ready;
    logic [sceex_pkg::DEC_W-1:0]  decoder_number;
    logic [sceex_pkg::SENS_W-1:0] sensor_number;
    logic                         new_level;
    logic                         last_event;

    modport source (output valid, output decoder_number, output sensor_number,
                    output new_level, output last_event, input ready);
    modport sink   (input valid, input decoder_number, input sensor_number,
                    input new_level, input last_event, output ready);
endinterface

/* hw/rtl/sceex_front.sv */
module sceex_front #(
    parameter int REPORT_BYTES = sceex_pkg::REPORT_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sceex_in_if.sink              in_ch,
    output logic                  push_valid,
    input  logic                  push_ready,
    output sceex_pkg::sceex_rec_t push_rec
);

    // Only indexes that the 4-bit field can reach need storage
    localparam int MAX_REACH   = 1 << sceex_pkg::IDX_W;
    localparam int STORE_DEPTH = (REPORT_BYTES < MAX_REACH) ? REPORT_BYTES : MAX_REACH;
    localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [sceex_pkg::BYTE_W-1:0] saved_reg [STORE_DEPTH];
    logic [SIDX_W-1:0]            slot;
    logic                         in_range;
    logic                         accept;
    logic [sceex_pkg::BYTE_W-1:0] diff;

    // Classify the incoming byte against its saved copy
    always_comb
    begin
        slot       = in_ch.byte_index[SIDX_W-1:0];
        in_range   = (int'(in_ch.byte_index) < REPORT_BYTES);
        in_ch.ready = push_ready;
        accept     = in_ch.valid && push_ready;
        diff       = in_range ? (saved_reg[slot] ^ in_ch.byte_value) : '0;
        push_valid = accept && in_range && (diff != '0);
        push_rec.byte_index = in_ch.byte_index;
        push_rec.byte_value = in_ch.byte_value;
        push_rec.diff       = diff;
    end

    // Store the new byte on every in-range transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                saved_reg[i] <= '0;
            end
        end
        else if (accept && in_range)
        begin
            saved_reg[slot] <= in_ch.byte_value;
        end
    end

endmodule

/* hw/rtl/sceex_queue.sv */
module sceex_queue #(
    parameter int DEPTH = sceex_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  sceex_pkg::sceex_rec_t push_rec,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output sceex_pkg::sceex_rec_t pop_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sceex_pkg::sceex_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  do_push;
    logic                  do_pop;

    // Work out pointer and fill updates
    always_comb
    begin
        push_ready = (count_reg != CNT_W'(DEPTH));
        pop_valid  = (count_reg != '0);
        pop_rec    = entry_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued records
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* hw/rtl/sceex_back.sv */
module sceex_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  sceex_pkg::sceex_rec_t pop_rec,
    sceex_out_if.source           out_ch
);

    localparam int BYTE_W = sceex_pkg::BYTE_W;
    localparam int BIT_W  = sceex_pkg::BIT_W;
    localparam int SENS_W = sceex_pkg::SENS_W;
    localparam int DEC_W  = sceex_pkg::DEC_W;
    localparam int IDX_W  = sceex_pkg::IDX_W;

    logic                  cur_valid_reg;
    logic                  cur_valid_next;
    sceex_pkg::sceex_rec_t cur_reg;
    sceex_pkg::sceex_rec_t cur_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DEC_W-1:0]      dec_reg;
    logic [SENS_W-1:0]     sens_reg;
    logic                  level_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  emit;
    logic                  found;
    logic [BIT_W-1:0]      bit_sel;
    logic [BYTE_W-1:0]     mask_left;
    logic                  is_last;
    logic [SENS_W-1:0]     sens_base;
    logic [SENS_W-1:0]     sens_val;

    // Pick the lowest changed bit
    always_comb
    begin
        bit_sel = '0;
        found   = 1'b0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (!found && cur_reg.diff[i])
            begin
                bit_sel = BIT_W'(i);
                found   = 1'b1;
            end
        end
    end

    // Step through the changed bits, one event per cycle while the output register is free
    always_comb
    begin
        out_free  = !out_valid_reg || out_ch.ready;
        emit      = cur_valid_reg && out_free;
        mask_left = cur_reg.diff & (cur_reg.diff - BYTE_W'(1));
        is_last   = (mask_left == '0);
        pop_ready = !cur_valid_reg || (emit && is_last);
        sens_base = cur_reg.byte_index[0] ? SENS_W'(2 * BYTE_W) : SENS_W'(BYTE_W);
        sens_val  = sens_base - {{(SENS_W - BIT_W){1'b0}}, bit_sel};

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (pop_ready)
        begin
            cur_valid_next = pop_valid;
            cur_next       = pop_rec;
        end
        else if (emit)
        begin
            cur_next.diff = mask_left;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working record and event payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            dec_reg   <= cur_reg.byte_index[IDX_W-1:1];
            sens_reg  <= sens_val;
            level_reg <= cur_reg.byte_value[bit_sel];
            last_reg  <= is_last;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.decoder_number = dec_reg;
    assign out_ch.sensor_number  = sens_reg;
    assign out_ch.new_level      = level_reg;
    assign out_ch.last_event     = last_reg;

endmodule

/* hw/rtl/sensor_change_event_extractor_core.sv */
// Sensor change event extractor.
// in_ch carries one report byte (byte_index, byte_value) per transfer. The
// block keeps the last byte seen at each index and, for every bit that
// changed, sends one event on out_ch: decoder_number = index/2,
// sensor_number = 8*(index mod 2) + 8 - bit, new_level, and last_event on
// the final event of the byte. Bits are scanned from bit 0 upward. An
// unchanged byte, or an index at or above REPORT_BYTES, gives no event.
// The first event of a byte passes the queue, the working record and
// the output register. Throughput: the event generator emits one event
// per cycle while out_ch is not stalled; a byte has at most eight
// changed bits, and an unchanged byte never enters the queue. A two-entry
// queue sits between the classifier and the event generator, so input is
// taken while events are still pending or waiting on out_ch.
// Reset clears every saved byte to zero and empties queue and output.
// When out_ch stalls the event is held; once the queue fills, in_ch.ready
// drops until the generator frees an entry.
module sensor_change_event_extractor_core #(
    parameter int REPORT_BYTES = sceex_pkg::REPORT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sceex_in_if.sink    in_ch,
    sceex_out_if.source out_ch
);

    logic                  push_valid;
    logic                  push_ready;
    sceex_pkg::sceex_rec_t push_rec;
    logic                  pop_valid;
    logic                  pop_ready;
    sceex_pkg::sceex_rec_t pop_rec;

    sceex_front #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    sceex_queue #(
        .DEPTH (sceex_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    sceex_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_rec   (pop_rec),
        .out_ch    (out_ch)
    );

endmodule

/* hw/rtl/sceex_checker.sv */
module sceex_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [sceex_pkg::DEC_W-1:0]  decoder_number,
    input logic [sceex_pkg::SENS_W-1:0] sensor_number,
    input logic                         new_level,
    input logic                         last_event
);

    // Hold a stalled event
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("event dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(decoder_number) && $stable(sensor_number)
            && $stable(new_level) && $stable(last_event))
        else $error("event payload changed while stalled");

    // Sensor numbers lie in one to sixteen
    a_sens_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sensor_number != '0) && (sensor_number <= 5'd16))
        else $error("sensor number out of range");

    // Events of one byte follow back to back from the same decoder
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_event |=> out_valid
            && (decoder_number == $past(decoder_number)))
        else $error("byte's event burst broken");

    // Sensor numbers fall within a byte's burst as bits are scanned upward
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_event |=> sensor_number < $past(sensor_number))
        else $error("events out of bit order");

endmodule

bind sensor_change_event_extractor_core sceex_checker u_sceex_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .decoder_number (out_ch.decoder_number),
    .sensor_number  (out_ch.sensor_number),
    .new_level      (out_ch.new_level),
    .last_event     (out_ch.last_event)
);
